@@ sv/lrupr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared constants and the control word between the sequencer and the
// frame memory.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int PAGE_W  = 16;
    localparam int SLOT_W  = 3;
    localparam int FAULT_W = 32;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef struct packed {
        logic rd_en;
        logic page_we;
        logic rank_we;
    } t_mem_ctl;

endpackage
`default_nettype wire

@@ sv/lrupr_frame_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LRU frame memory
// Page store and recency rank store, one write port and one read port each,
// with registered read data.
// ----------------------------------------------------------------------------
module lrupr_frame_mem #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16,
    parameter int IDX_W      = 3
) (
    input  wire                    i_clk,
    input  lrupr_pkg::t_mem_ctl    i_ctl,
    input  wire [IDX_W-1:0]        i_rd_addr,
    input  wire [IDX_W-1:0]        i_wr_addr,
    input  wire [PAGE_BITS-1:0]    i_wr_page,
    input  wire [IDX_W-1:0]        i_wr_rank,
    output logic [PAGE_BITS-1:0]   o_rd_page,
    output logic [IDX_W-1:0]       o_rd_rank
);
    import lrupr_pkg::*;

    logic [PAGE_BITS-1:0] r_page_mem [MAX_FRAMES];
    logic [IDX_W-1:0]     r_rank_mem [MAX_FRAMES];

    always_ff @(posedge i_clk) begin
        if (i_ctl.page_we) begin
            r_page_mem[i_wr_addr] <= i_wr_page;
        end
        if (i_ctl.rank_we) begin
            r_rank_mem[i_wr_addr] <= i_wr_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_page <= r_page_mem[i_rd_addr];
            o_rd_rank <= r_rank_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ sv/lrupr_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LRU sequencer
// Scans the active frames one per cycle, picks the frame for the page, and
// sweeps the rank store to keep the recency order.
// ----------------------------------------------------------------------------
module lrupr_seq #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16,
    parameter int IDX_W      = 3,
    parameter int CNT_W      = 4
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire [PAGE_BITS-1:0]            i_page,
    input  wire                            i_final,
    input  wire [CNT_W-1:0]                i_frames,
    input  wire [PAGE_BITS-1:0]            i_rd_page,
    input  wire [IDX_W-1:0]                i_rd_rank,
    output lrupr_pkg::t_mem_ctl            o_ctl,
    output logic [IDX_W-1:0]               o_rd_addr,
    output logic [IDX_W-1:0]               o_wr_addr,
    output logic [PAGE_BITS-1:0]           o_wr_page,
    output logic [IDX_W-1:0]               o_wr_rank,
    output logic                           o_busy,
    output logic                           o_strobe,
    output logic                           o_hit,
    output logic [IDX_W-1:0]               o_slot,
    output logic [lrupr_pkg::FAULT_W-1:0]  o_fault,
    output logic                           o_final
);
    import lrupr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_PLAN = 4'b0100,
        S_UPD  = 4'b1000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FRAMES - 1);

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [PAGE_BITS-1:0]   r_page, n_page;
    logic                   r_final, n_final;
    logic                   r_hit_fnd, n_hit_fnd;
    logic [IDX_W-1:0]       r_hit_idx, n_hit_idx;
    logic [IDX_W-1:0]       r_hit_rank, n_hit_rank;
    logic                   r_emp_fnd, n_emp_fnd;
    logic [IDX_W-1:0]       r_emp_idx, n_emp_idx;
    logic [IDX_W-1:0]       r_min_idx, n_min_idx;
    logic [IDX_W-1:0]       r_min_rank, n_min_rank;
    logic [IDX_W-1:0]       r_slot, n_slot;
    logic [IDX_W-1:0]       r_old_rank, n_old_rank;
    logic                   r_res_hit, n_res_hit;
    logic [MAX_FRAMES-1:0]  r_valid, n_valid;
    logic [CNT_W-1:0]       r_vcnt, n_vcnt;
    logic [FAULT_W-1:0]     r_fault, n_fault;
    logic                   r_strobe, n_strobe;

    logic [IDX_W-1:0]       idx_inc;
    logic                   cur_valid;
    logic [IDX_W-1:0]       top_rank;

    assign idx_inc   = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    assign cur_valid = r_valid[r_idx];
    assign top_rank  = IDX_W'(r_vcnt - 1'b1);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_page     = r_page;
        n_final    = r_final;
        n_hit_fnd  = r_hit_fnd;
        n_hit_idx  = r_hit_idx;
        n_hit_rank = r_hit_rank;
        n_emp_fnd  = r_emp_fnd;
        n_emp_idx  = r_emp_idx;
        n_min_idx  = r_min_idx;
        n_min_rank = r_min_rank;
        n_slot     = r_slot;
        n_old_rank = r_old_rank;
        n_res_hit  = r_res_hit;
        n_valid    = r_valid;
        n_vcnt     = r_vcnt;
        n_fault    = r_fault;
        n_strobe   = 1'b0;
        o_ctl      = '0;
        o_rd_addr  = idx_inc;
        o_wr_addr  = r_slot;
        o_wr_page  = r_page;
        o_wr_rank  = top_rank;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state     = S_SCAN;
                    n_idx       = '0;
                    n_page      = i_page;
                    n_final     = i_final;
                    n_hit_fnd   = 1'b0;
                    n_emp_fnd   = 1'b0;
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = '0;
                end
            end
            S_SCAN: begin
                if (cur_valid && (i_rd_page == r_page) && !r_hit_fnd) begin
                    n_hit_fnd  = 1'b1;
                    n_hit_idx  = r_idx;
                    n_hit_rank = i_rd_rank;
                end
                if (!cur_valid && !r_emp_fnd) begin
                    n_emp_fnd = 1'b1;
                    n_emp_idx = r_idx;
                end
                if ((r_idx == '0) || (i_rd_rank < r_min_rank)) begin
                    n_min_idx  = r_idx;
                    n_min_rank = i_rd_rank;
                end
                if (CNT_W'(r_idx) == i_frames - 1'b1) begin
                    n_state = S_PLAN;
                end else begin
                    n_idx       = idx_inc;
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = idx_inc;
                end
            end
            S_PLAN: begin
                if (r_hit_fnd) begin
                    n_res_hit     = 1'b1;
                    n_slot        = r_hit_idx;
                    n_old_rank    = r_hit_rank;
                    o_wr_addr     = r_hit_idx;
                    o_wr_rank     = top_rank;
                    o_ctl.rank_we = 1'b1;
                    n_state       = S_UPD;
                    n_idx         = '0;
                    o_ctl.rd_en   = 1'b1;
                    o_rd_addr     = '0;
                end else begin
                    n_res_hit = 1'b0;
                    if (r_fault != '1) begin
                        n_fault = r_fault + 1'b1;
                    end
                    o_ctl.page_we = 1'b1;
                    o_ctl.rank_we = 1'b1;
                    if (r_emp_fnd) begin
                        n_slot             = r_emp_idx;
                        o_wr_addr          = r_emp_idx;
                        o_wr_rank          = IDX_W'(r_vcnt);
                        n_valid[r_emp_idx] = 1'b1;
                        n_vcnt             = r_vcnt + 1'b1;
                        n_strobe           = 1'b1;
                        n_state            = S_IDLE;
                    end else begin
                        n_slot      = r_min_idx;
                        n_old_rank  = r_min_rank;
                        o_wr_addr   = r_min_idx;
                        o_wr_rank   = top_rank;
                        n_state     = S_UPD;
                        n_idx       = '0;
                        o_ctl.rd_en = 1'b1;
                        o_rd_addr   = '0;
                    end
                end
            end
            S_UPD: begin
                o_wr_addr = r_idx;
                o_wr_rank = i_rd_rank - 1'b1;
                if ((r_idx != r_slot) && cur_valid && (i_rd_rank > r_old_rank)) begin
                    o_ctl.rank_we = 1'b1;
                end
                if (r_idx == LAST_IDX) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx       = idx_inc;
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = idx_inc;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_vcnt   <= '0;
            r_fault  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_vcnt   <= n_vcnt;
            r_fault  <= n_fault;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_page     <= n_page;
        r_final    <= n_final;
        r_hit_fnd  <= n_hit_fnd;
        r_hit_idx  <= n_hit_idx;
        r_hit_rank <= n_hit_rank;
        r_emp_fnd  <= n_emp_fnd;
        r_emp_idx  <= n_emp_idx;
        r_min_idx  <= n_min_idx;
        r_min_rank <= n_min_rank;
        r_slot     <= n_slot;
        r_old_rank <= n_old_rank;
        r_res_hit  <= n_res_hit;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_hit    = r_res_hit;
    assign o_slot   = r_slot;
    assign o_fault  = r_fault;
    assign o_final  = r_final;

endmodule
`default_nettype wire

@@ sv/lru_page_replacement_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement unit
// A reference is taken when start is high and busy is low. Its result word
// appears for exactly one cycle with o_strobe high and cannot be held off by
// the receiver. Busy stays high while the active frames are scanned one per
// cycle through the frame memory read port; a fault that fills an empty
// frame ends there, while a hit or a replacement is followed by one sweep
// over the rank store, one frame per cycle, covering all MAX_FRAMES frames.
// The result word shows in the first cycle that busy is low again, so the
// next reference can be taken in that same cycle.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire [lrupr_pkg::PAGE_W-1:0]    i_page,
    input  wire                            i_final_reference,
    input  wire                            i_cfg_we,
    input  wire [lrupr_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                           o_strobe,
    output logic                           o_hit,
    output logic [lrupr_pkg::SLOT_W-1:0]   o_frame_slot,
    output logic [lrupr_pkg::FAULT_W-1:0]  o_fault_total,
    output logic                           o_final_result
);
    import lrupr_pkg::*;

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    logic [CFG_W-1:0]     r_frames_in_use;
    logic [CNT_W-1:0]     active_frames;
    logic [47:0]          page_ext;
    logic [PAGE_BITS-1:0] page_masked;
    logic [IDX_W-1:0]     slot;
    logic [31:0]          slot_ext;

    t_mem_ctl             mem_ctl;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic [PAGE_BITS-1:0] wr_page;
    logic [IDX_W-1:0]     wr_rank;
    logic [PAGE_BITS-1:0] rd_page;
    logic [IDX_W-1:0]     rd_rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_frames_in_use <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_frames_in_use == '0) begin
            active_frames = CNT_W'(1);
        end else if (int'(r_frames_in_use) > MAX_FRAMES) begin
            active_frames = CNT_W'(MAX_FRAMES);
        end else begin
            active_frames = CNT_W'(r_frames_in_use);
        end
    end

    assign page_ext     = 48'(i_page);
    assign page_masked  = page_ext[PAGE_BITS-1:0];
    assign slot_ext     = 32'(slot);
    assign o_frame_slot = slot_ext[SLOT_W-1:0];

    lrupr_seq #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_page    (page_masked),
        .i_final   (i_final_reference),
        .i_frames  (active_frames),
        .i_rd_page (rd_page),
        .i_rd_rank (rd_rank),
        .o_ctl     (mem_ctl),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr),
        .o_wr_page (wr_page),
        .o_wr_rank (wr_rank),
        .o_busy    (busy),
        .o_strobe  (o_strobe),
        .o_hit     (o_hit),
        .o_slot    (slot),
        .o_fault   (o_fault_total),
        .o_final   (o_final_result)
    );

    lrupr_frame_mem #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .IDX_W      (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_page (wr_page),
        .i_wr_rank (wr_rank),
        .o_rd_page (rd_page),
        .o_rd_rank (rd_rank)
    );

endmodule
`default_nettype wire

@@ tb/lru_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Watches the reference and result channels of the page replacement unit.
// Every accepted reference is run through a local model of the frame set,
// which tracks pages, valid marks, recency ranks, the fault count and the
// frame count. The expected result word is queued, and each result word
// that comes out is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module lru_checker #(
    parameter int MAX_FRAMES = 8
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire                            i_busy,
    input  wire [lrupr_pkg::PAGE_W-1:0]    i_page,
    input  wire                            i_final_reference,
    input  wire                            i_cfg_we,
    input  wire [lrupr_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire                            i_strobe,
    input  wire                            i_hit,
    input  wire [lrupr_pkg::SLOT_W-1:0]    i_frame_slot,
    input  wire [lrupr_pkg::FAULT_W-1:0]   i_fault_total,
    input  wire                            i_final_result,
    output int                             o_fail_count,
    output int                             o_pending
);
    import lrupr_pkg::*;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [FAULT_W-1:0] faults;
        logic               final_result;
    } t_lru_word;

    logic [PAGE_W-1:0]  frame_page  [MAX_FRAMES];
    logic               frame_valid [MAX_FRAMES];
    logic [2:0]         frame_rank  [MAX_FRAMES];
    logic [FAULT_W-1:0] fault_count;
    logic [CFG_W-1:0]   frame_count;
    t_lru_word          expected_words[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int valid_frames();
        int n;
        n = 0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (frame_valid[i]) begin
                n++;
            end
        end
        return n;
    endfunction

    // The frame becomes the most recent one; ranks above its old rank move down.
    task automatic make_newest(input int s);
        logic [2:0] old_rank;
        old_rank = frame_rank[s];
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (i != s && frame_valid[i] && frame_rank[i] > old_rank) begin
                frame_rank[i] = frame_rank[i] - 3'd1;
            end
        end
        frame_rank[s] = 3'(valid_frames() - 1);
    endtask

    task automatic predict_reference(input logic [PAGE_W-1:0] pg, input logic fin);
        int        active;
        int        slot;
        bit        found;
        t_lru_word w;
        active = (frame_count == 0) ? 1 :
                 (frame_count > MAX_FRAMES) ? MAX_FRAMES : int'(frame_count);
        found = 1'b0;
        slot  = 0;
        for (int i = 0; i < active; i++) begin
            if (!found && frame_valid[i] && frame_page[i] == pg) begin
                found = 1'b1;
                slot  = i;
            end
        end
        w.hit = found;
        if (found) begin
            make_newest(slot);
        end else begin
            for (int i = 0; i < active; i++) begin
                if (!found && !frame_valid[i]) begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (found) begin
                frame_rank[slot]  = 3'(valid_frames());
                frame_valid[slot] = 1'b1;
                frame_page[slot]  = pg;
            end else begin
                slot = 0;
                for (int i = 1; i < active; i++) begin
                    if (frame_rank[i] < frame_rank[slot]) begin
                        slot = i;
                    end
                end
                frame_page[slot] = pg;
                make_newest(slot);
            end
            if (fault_count != '1) begin
                fault_count = fault_count + 1'b1;
            end
        end
        w.slot         = slot[SLOT_W-1:0];
        w.faults       = fault_count;
        w.final_result = fin;
        expected_words.push_back(w);
    endtask

    task automatic report_mismatch(input string what, input t_lru_word e);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t: %s: expected hit=%0d slot=%0d faults=%0d final=%0d, got hit=%0d slot=%0d faults=%0d final=%0d",
                     $time, what, e.hit, e.slot, e.faults, e.final_result,
                     i_hit, i_frame_slot, i_fault_total, i_final_result);
        end
    endtask

    always @(posedge i_clk) begin
        t_lru_word e;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                frame_page[i]  = '0;
                frame_valid[i] = 1'b0;
                frame_rank[i]  = '0;
            end
            fault_count = '0;
            frame_count = CFG_RESET;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                frame_count = i_cfg_wdata;
            end
            if (i_strobe) begin
                if (expected_words.size() == 0) begin
                    e = '0;
                    report_mismatch("unexpected result word", e);
                end else begin
                    e = expected_words.pop_front();
                    if (i_hit !== e.hit || i_frame_slot !== e.slot
                        || i_fault_total !== e.faults || i_final_result !== e.final_result) begin
                        report_mismatch("result word mismatch", e);
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_reference(i_page, i_final_reference);
            end
        end
        o_pending = expected_words.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page replacement unit testbench
// Drives directed references over the frame count extremes, then phases of
// random references drawn mostly from a small page pool so that hits and
// replacements are frequent, with random gaps between words except in every
// fourth phase. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
    import lrupr_pkg::*;

    logic               i_clk;
    logic               i_rst_n           = 1'b0;
    logic               start             = 1'b0;
    logic               busy;
    logic [PAGE_W-1:0]  i_page            = '0;
    logic               i_final_reference = 1'b0;
    logic               i_cfg_we          = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata       = '0;
    logic               o_strobe;
    logic               o_hit;
    logic [SLOT_W-1:0]  o_frame_slot;
    logic [FAULT_W-1:0] o_fault_total;
    logic               o_final_result;
    int                 fail_count;
    int                 pending_words;
    bit                 no_gaps = 1'b0;
    logic [PAGE_W-1:0]  page_pool[$];

    lru_page_replacement_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_page            (i_page),
        .i_final_reference (i_final_reference),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_strobe          (o_strobe),
        .o_hit             (o_hit),
        .o_frame_slot      (o_frame_slot),
        .o_fault_total     (o_fault_total),
        .o_final_result    (o_final_result)
    );

    lru_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_page            (i_page),
        .i_final_reference (i_final_reference),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_strobe          (o_strobe),
        .i_hit             (o_hit),
        .i_frame_slot      (o_frame_slot),
        .i_fault_total     (o_fault_total),
        .i_final_result    (o_final_result),
        .o_fail_count      (fail_count),
        .o_pending         (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #500000;
        $display("*** FAILED ***");
        $finish;
    end

    // Called and returning at a falling edge; start stays high when no gap follows.
    task automatic send_reference(input logic [PAGE_W-1:0] pg, input logic fin);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start             <= 1'b1;
        i_page            <= pg;
        i_final_reference <= fin;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic drain_words();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_words != 0);
    endtask

    task automatic set_frames(input logic [CFG_W-1:0] count);
        drain_words();
        repeat (20) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        logic [CFG_W-1:0] phase_frames[12] = '{4'd1, 4'd15, 4'd3, 4'd9, 4'd8, 4'd5,
                                               4'd2, 4'd12, 4'd7, 4'd4, 4'd6, 4'd0};
        int               active;
        int               pick;
        logic [PAGE_W-1:0] pg;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Eight frames after reset: fill them, hit, then replace the least recent.
        send_reference(16'h0000, 1'b0);
        send_reference(16'hFFFF, 1'b0);
        send_reference(16'h00FF, 1'b0);
        send_reference(16'hFF00, 1'b0);
        send_reference(16'h5555, 1'b0);
        send_reference(16'hAAAA, 1'b0);
        send_reference(16'h0F0F, 1'b0);
        send_reference(16'hF0F0, 1'b0);
        send_reference(16'h0000, 1'b0);
        send_reference(16'h1234, 1'b0);
        send_reference(16'hFFFF, 1'b0);
        send_reference(16'h1234, 1'b1);

        // A frame count of zero acts as one; frames beyond it keep their pages.
        set_frames(4'd0);
        send_reference(16'h00FF, 1'b0);
        send_reference(16'h00FF, 1'b0);
        send_reference(16'hBEEF, 1'b1);

        // A count above the frame total acts as the total.
        set_frames(4'd15);
        send_reference(16'h5555, 1'b0);
        send_reference(16'hBEEF, 1'b0);
        send_reference(16'h0001, 1'b0);
        send_reference(16'h8000, 1'b0);
        send_reference(16'h0F0F, 1'b1);

        for (int p = 0; p < 12; p++) begin
            set_frames(phase_frames[p]);
            no_gaps = (p % 4 == 2);
            active  = (phase_frames[p] == 0) ? 1 :
                      (phase_frames[p] > 8) ? 8 : int'(phase_frames[p]);
            page_pool.delete();
            repeat (active + $urandom_range(0, 4)) page_pool.push_back(PAGE_W'($urandom()));
            for (int n = 0; n < 52; n++) begin
                if (n == 26 && p % 3 == 0) begin
                    drain_words();
                end
                if ($urandom_range(0, 99) < 85) begin
                    pick = $urandom_range(0, page_pool.size() - 1);
                    pg   = page_pool[pick];
                end else begin
                    pg = PAGE_W'($urandom());
                end
                send_reference(pg, $urandom_range(0, 9) == 0);
            end
        end

        drain_words();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending_words == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/lrupr_pkg.sv
sv/lrupr_frame_mem.sv
sv/lrupr_seq.sv
sv/lru_page_replacement_unit.sv
tb/lru_checker.sv
tb/tb.sv
